### sv/sit_pkg.sv
// Shared constants, types and hash helper for the string interning table.
package sit_pkg;

    localparam int MAX_CHARS   = 32;
    // power of two: the home slot is the low hash bits
    localparam int TABLE_SLOTS = 64;

    localparam int UNIT_W  = 16;
    localparam int ID_W    = 16;
    localparam int ST_W    = 2;
    localparam int HASH_W  = 32;
    localparam int LEN_W   = $clog2(MAX_CHARS + 1);
    localparam int CIDX_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CADDR_W = $clog2(TABLE_SLOTS * MAX_CHARS);

    // result status codes
    localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [ST_W-1:0] ST_NEW      = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_TOO_LONG = 2'd3;

    localparam logic [ID_W-1:0]   ID_LIMIT  = 16'hFFFF;
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [CIDX_W-1:0]  t_cidx;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CADDR_W-1:0] t_caddr;
    typedef logic [HASH_W-1:0]  t_hash;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [UNIT_W-1:0]  t_unit;
    typedef logic [ST_W-1:0]    t_status;

    // per-slot metadata, stored as one word
    typedef struct packed {
        t_len  len;
        t_hash hash;
        t_id   ident;
    } t_meta;

    // table access command: reads always happen at slot/cidx
    typedef struct packed {
        logic  chr_we;
        logic  meta_we;
        t_slot slot;
        t_cidx cidx;
        t_unit chr_wdata;
        t_meta meta;
    } t_tbl_cmd;

    // registered table read data
    typedef struct packed {
        logic  used;
        t_meta meta;
        t_unit chr;
    } t_tbl_rsp;

    // one FNV-1a byte step
    function automatic t_hash fnv_mix(t_hash h, logic [7:0] b);
        t_hash x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

### sv/sit_if.sv
// Valid/ready channel interfaces for input code units and lookup results.
interface sit_in_if;
    logic                 valid;
    logic                 ready;
    sit_pkg::t_unit       code_unit;
    logic                 end_of_string;
    modport source (output valid, output code_unit, output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface sit_out_if;
    logic                 valid;
    logic                 ready;
    sit_pkg::t_id         string_id;
    sit_pkg::t_status     status;
    modport source (output valid, output string_id, output status, input ready);
    modport sink   (input valid, input string_id, input status, output ready);
endinterface

### sv/sit_pend.sv
// Buffer memory for the code units of the string being collected.
module sit_pend (
    input  logic           i_clk,
    input  logic           i_we,
    input  sit_pkg::t_cidx i_waddr,
    input  sit_pkg::t_unit i_wdata,
    input  sit_pkg::t_cidx i_raddr,
    output sit_pkg::t_unit o_rdata
);
    import sit_pkg::*;

    t_unit r_mem [MAX_CHARS];
    t_unit r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sit_table.sv
// Slot storage: character memory, metadata memory and per-slot used bits.
module sit_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sit_pkg::t_tbl_cmd i_cmd,
    output sit_pkg::t_tbl_rsp o_rsp
);
    import sit_pkg::*;

    t_unit             r_chars [TABLE_SLOTS * MAX_CHARS];
    t_meta             r_meta  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_used;
    t_unit             r_chr_q;
    t_meta             r_meta_q;
    logic              r_used_q;
    t_caddr            w_caddr;

    assign w_caddr = t_caddr'(i_cmd.slot) * t_caddr'(MAX_CHARS) + t_caddr'(i_cmd.cidx);

    // character memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.chr_we) begin
            r_chars[w_caddr] <= i_cmd.chr_wdata;
        end
        r_chr_q <= r_chars[w_caddr];
    end

    // metadata memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_we) begin
            r_meta[i_cmd.slot] <= i_cmd.meta;
        end
        r_meta_q <= r_meta[i_cmd.slot];
    end

    // used bits, cleared at reset so every slot starts empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_used_q <= 1'b0;
        end else begin
            if (i_cmd.meta_we) begin
                r_used[i_cmd.slot] <= 1'b1;
            end
            r_used_q <= r_used[i_cmd.slot];
        end
    end

    assign o_rsp = '{used: r_used_q, meta: r_meta_q, chr: r_chr_q};

endmodule

### sv/string_interning_table.sv
// Top level: string collection, hashing, probe sequencer and result register.
//
//  channel | dir | payload                    | transfer when
//  i_in    | in  | code_unit, end_of_string   | valid & ready
//  o_out   | out | string_id, status          | valid & ready
//
// A code unit is hashed in two byte steps, low byte then high byte; a dropped
// unit is not hashed. An end item hashes the length, then reads and checks
// each probed slot and compares its characters; on insertion it copies each
// character and writes the metadata, then loads the result; a too-long end
// item goes straight to the result. The slot memories are single-port.
// Reset is synchronous; all slots come out empty at once, no clearing pass.
// The result register lets lookup finish while the previous result is held;
// a full result register stalls the sequencer in its final state.
module string_interning_table (
    input  logic i_clk,
    input  logic i_rst_n,
    sit_in_if.sink    i_in,
    sit_out_if.source o_out
);
    import sit_pkg::*;

    localparam logic [3:0] S_IN  = 4'd0;
    localparam logic [3:0] S_HB  = 4'd1;
    localparam logic [3:0] S_L0  = 4'd2;
    localparam logic [3:0] S_L1  = 4'd3;
    localparam logic [3:0] S_PRD = 4'd5;
    localparam logic [3:0] S_PCK = 4'd6;
    localparam logic [3:0] S_CRD = 4'd7;
    localparam logic [3:0] S_CCK = 4'd8;
    localparam logic [3:0] S_CPR = 4'd9;
    localparam logic [3:0] S_CPW = 4'd10;
    localparam logic [3:0] S_META = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]        r_state, n_state;
    t_len              r_plen, n_plen;
    logic              r_tl, n_tl;
    t_hash             r_h, n_h;
    logic [7:0]        r_hb, n_hb;
    t_slot             r_slot, n_slot;
    logic [SLOT_W:0]   r_n, n_n;
    t_len              r_i, n_i;
    t_id               r_ident, n_ident;
    t_id               r_count, n_count;
    t_id               r_res_id, n_res_id;
    t_status           r_res_st, n_res_st;
    logic              r_ov, n_ov;
    t_id               r_oid, n_oid;
    t_status           r_ost, n_ost;

    logic              w_pend_we;
    t_cidx             w_pend_waddr;
    t_unit             w_pend_rdata;
    t_tbl_cmd          w_cmd;
    t_tbl_rsp          w_rsp;
    logic              w_in_xfer;
    logic [15:0]       w_len16;
    t_hash             w_h2;
    t_slot             w_next_slot;
    logic              w_full;
    logic              w_last_probe;

    sit_pend u_pend (
        .i_clk   (i_clk),
        .i_we    (w_pend_we),
        .i_waddr (w_pend_waddr),
        .i_wdata (i_in.code_unit),
        .i_raddr (r_i[CIDX_W-1:0]),
        .o_rdata (w_pend_rdata)
    );

    sit_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready  = (r_state == S_IN);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_pend_we   = w_in_xfer && !i_in.end_of_string && (r_plen < t_len'(MAX_CHARS));
    assign w_pend_waddr = r_plen[CIDX_W-1:0];

    assign w_len16 = 16'(r_plen);
    assign w_h2    = fnv_mix(r_h, w_len16[15:8]);

    assign w_next_slot  = (r_slot == t_slot'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
    assign w_last_probe = ((r_n + 1'b1) == (SLOT_W+1)'(TABLE_SLOTS));
    assign w_full = (17'({r_count, 1'b0}) >= 17'(TABLE_SLOTS)) || (r_count >= ID_LIMIT);

    // table command: reads follow slot/index, writes in copy and meta states
    always_comb begin
        w_cmd           = '0;
        w_cmd.slot      = r_slot;
        w_cmd.cidx      = r_i[CIDX_W-1:0];
        w_cmd.chr_we    = (r_state == S_CPW);
        w_cmd.chr_wdata = w_pend_rdata;
        w_cmd.meta_we   = (r_state == S_META);
        w_cmd.meta.len  = r_plen;
        w_cmd.meta.hash = r_h;
        w_cmd.meta.ident = r_count + 1'b1;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_plen   = r_plen;
        n_tl     = r_tl;
        n_h      = r_h;
        n_hb     = r_hb;
        n_slot   = r_slot;
        n_n      = r_n;
        n_i      = r_i;
        n_ident  = r_ident;
        n_count  = r_count;
        n_res_id = r_res_id;
        n_res_st = r_res_st;
        n_ov     = r_ov;
        n_oid    = r_oid;
        n_ost    = r_ost;

        if (o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IN: begin
                if (w_in_xfer) begin
                    if (!i_in.end_of_string) begin
                        if (r_plen < t_len'(MAX_CHARS)) begin
                            n_plen  = r_plen + 1'b1;
                            n_h     = fnv_mix(r_h, i_in.code_unit[7:0]);
                            n_hb    = i_in.code_unit[15:8];
                            n_state = S_HB;
                        end else begin
                            n_tl = 1'b1;
                        end
                    end else if (r_tl) begin
                        n_res_id = '0;
                        n_res_st = ST_TOO_LONG;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_L0;
                    end
                end
            end
            S_HB: begin
                n_h     = fnv_mix(r_h, r_hb);
                n_state = S_IN;
            end
            S_L0: begin
                n_h     = fnv_mix(r_h, w_len16[7:0]);
                n_state = S_L1;
            end
            S_L1: begin
                n_h     = w_h2;
                n_n     = '0;
                n_slot  = w_h2[SLOT_W-1:0];
                n_state = S_PRD;
            end
            S_PRD: begin
                n_state = S_PCK;
            end
            S_PCK: begin
                n_ident = w_rsp.meta.ident;
                n_i     = '0;
                if (!w_rsp.used) begin
                    if (w_full) begin
                        n_res_id = '0;
                        n_res_st = ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_plen == '0) begin
                        n_state = S_META;
                    end else begin
                        n_state = S_CPR;
                    end
                end else if (w_rsp.meta.hash == r_h && w_rsp.meta.len == r_plen) begin
                    if (r_plen == '0) begin
                        n_res_id = w_rsp.meta.ident;
                        n_res_st = ST_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CRD;
                    end
                end else if (w_last_probe) begin
                    n_res_id = '0;
                    n_res_st = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_slot  = w_next_slot;
                    n_state = S_PRD;
                end
            end
            S_CRD: begin
                n_state = S_CCK;
            end
            S_CCK: begin
                if (w_pend_rdata != w_rsp.chr) begin
                    if (w_last_probe) begin
                        n_res_id = '0;
                        n_res_st = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_slot  = w_next_slot;
                        n_state = S_PRD;
                    end
                end else if ((r_i + 1'b1) == r_plen) begin
                    n_res_id = r_ident;
                    n_res_st = ST_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CPR: begin
                n_state = S_CPW;
            end
            S_CPW: begin
                if ((r_i + 1'b1) == r_plen) begin
                    n_state = S_META;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CPR;
                end
            end
            S_META: begin
                n_count  = r_count + 1'b1;
                n_res_id = r_count + 1'b1;
                n_res_st = ST_NEW;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_oid   = r_res_id;
                    n_ost   = r_res_st;
                    n_plen  = '0;
                    n_tl    = 1'b0;
                    n_h     = FNV_BASIS;
                    n_state = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_plen  <= '0;
            r_tl    <= 1'b0;
            r_h     <= FNV_BASIS;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_tl    <= n_tl;
            r_h     <= n_h;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_hb     <= n_hb;
        r_slot   <= n_slot;
        r_n      <= n_n;
        r_i      <= n_i;
        r_ident  <= n_ident;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        r_oid    <= n_oid;
        r_ost    <= n_ost;
    end

    assign o_out.valid     = r_ov;
    assign o_out.string_id = r_oid;
    assign o_out.status    = r_ost;

    // a new entry always carries a nonzero id
    a_new_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_NEW) |-> (o_out.string_id != '0))
        else $error("new entry with zero id");

    // refused strings report id zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_FULL || o_out.status == ST_TOO_LONG))
        |-> (o_out.string_id == '0))
        else $error("refused string with nonzero id");

    // occupancy never passes half load
    a_half_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (17'({r_count, 1'b0}) <= 17'(TABLE_SLOTS) + 17'd1))
        else $error("table above half load");

    // an insertion bumps the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META) |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry count did not advance on insert");

endmodule
